>>> hw/rtl/ncm_pkg.sv
// ----------------------------------------------------------------------------
// ncm_pkg
// shared types, constants and the compare-select function of the
// nearest palette colour match core
// ----------------------------------------------------------------------------
`default_nettype none

package ncm_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned DistW    = 10;
  localparam int unsigned ColIdxW  = 4;
  // width of the node index in the selection tree (room for 256 entries)
  localparam int unsigned NodeIdxW = 8;

  localparam logic [DistW-1:0] ThresholdReset  = DistW'(200);
  localparam logic [DistW-1:0] NoMatchDistance = DistW'(766);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_MATCH = 1'b1
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [ColIdxW-1:0] entry_index;
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
  } in_item_t;

  typedef struct packed {
    logic [ColIdxW-1:0] color_index;
    logic               found;
    logic [DistW-1:0]   best_distance;
  } out_item_t;

  // one candidate in the selection tree
  typedef struct packed {
    logic                ok;
    logic [DistW-1:0]    l1_dist;
    logic [NodeIdxW-1:0] idx;
  } node_t;

  // lower half of the palette on the left: on a tie the left one wins
  function automatic node_t pick(input node_t lo, input node_t hi);
    node_t res;
    if (lo.ok && (!hi.ok || (lo.l1_dist <= hi.l1_dist))) begin
      res = lo;
    end else begin
      res = hi;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ncm_lane.sv
// ----------------------------------------------------------------------------
// ncm_lane
// one palette entry and its L1 distance to the incoming pixel
// ----------------------------------------------------------------------------
`default_nettype none

module ncm_lane #(
  parameter int unsigned LaneIdx = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic                          wr_en_i,
  input  wire ncm_pkg::in_item_t             item_i,
  input  wire logic [ncm_pkg::DistW-1:0]     thresh_i,
  output      ncm_pkg::node_t                node_o
);

  logic [ncm_pkg::ChanW-1:0] red_q, green_q, blue_q;
  logic [ncm_pkg::ChanW-1:0] dr, dg, db;
  logic [ncm_pkg::DistW-1:0] l1_dist;
  ncm_pkg::node_t            node_q;

  always_comb begin
    dr      = (item_i.red > red_q) ? (item_i.red - red_q) : (red_q - item_i.red);
    dg      = (item_i.green > green_q) ? (item_i.green - green_q)
                                       : (green_q - item_i.green);
    db      = (item_i.blue > blue_q) ? (item_i.blue - blue_q) : (blue_q - item_i.blue);
    l1_dist = ncm_pkg::DistW'(dr) + ncm_pkg::DistW'(dg) + ncm_pkg::DistW'(db);
  end

  // palette entry, undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      red_q   <= item_i.red;
      green_q <= item_i.green;
      blue_q  <= item_i.blue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      node_q.ok      <= (l1_dist < thresh_i);
      node_q.l1_dist <= l1_dist;
      node_q.idx     <= ncm_pkg::NodeIdxW'(LaneIdx);
    end
  end

  assign node_o = node_q;

endmodule

`default_nettype wire

>>> hw/rtl/ncm_tree.sv
// ----------------------------------------------------------------------------
// ncm_tree
// registered pairwise minimum tree, one level per stage
// ----------------------------------------------------------------------------
`default_nettype none

module ncm_tree #(
  parameter int unsigned Levels = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           vld_i,
  input  wire ncm_pkg::node_t leaf_i [(1 << Levels)],
  output      ncm_pkg::node_t root_o,
  output      logic           vld_o
);

  localparam int unsigned NumLeaves = 1 << Levels;

  // heap order: node k takes nodes 2k and 2k+1, leaves at NumLeaves and up
  ncm_pkg::node_t heap [1:2*NumLeaves-1];
  logic [Levels-1:0] vld_q;

  // valid bits move one level up per stage
  function automatic logic [Levels-1:0] shift_in(input logic [Levels-1:0] v,
                                                 input logic              b);
    logic [Levels:0] t;
    t = {v, b};
    return t[Levels-1:0];
  endfunction

  for (genvar l = 0; l < NumLeaves; l++) begin : g_leaf
    assign heap[NumLeaves+l] = leaf_i[l];
  end

  for (genvar k = 1; k < NumLeaves; k++) begin : g_node
    ncm_pkg::node_t node_q;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        node_q <= ncm_pkg::pick(heap[2*k], heap[2*k+1]);
      end
    end
    assign heap[k] = node_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= shift_in(vld_q, vld_i);
    end
  end

  assign root_o = heap[1];
  assign vld_o  = vld_q[Levels-1];

endmodule

`default_nettype wire

>>> hw/rtl/nearest_palette_color_match_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core
// maps rgb pixels to the nearest palette entry by L1 distance
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid_i / in_stall_o / in_data_i. a word with action
//                 write loads one palette entry and gives no result; a word
//                 with action match gives one result word
//   out channel : out_valid_o / out_stall_i / out_data_o (index, found flag,
//                 distance; 766 and index 0 when nothing is below threshold)
//   cfg channel : cfg_valid_i / cfg_ready_o / cfg_data_i writes the match
//                 threshold; the user must write it only while the core is
//                 idle, the core does not enforce it; ready is always high
// pipeline      : 1 + log2(PALETTE_SIZE) register stages (5 for 16 entries):
//                 one distance stage, then one stage per level of the minimum
//                 tree; the result comes from the root register of the tree
// throughput    : one word per cycle unless a stalled result holds the
//                 pipeline, writes and matches freely mixed
// reset         : clears the pipeline valid bits and sets the threshold to
//                 200; palette contents are undefined until written
// stall         : a stalled result freezes the whole pipeline, in_stall_o
//                 rises in the same cycle and nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_match_core #(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // pixel / palette words
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire ncm_pkg::in_item_t             in_data_i,
  // result words
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      ncm_pkg::out_item_t            out_data_o,
  // threshold register
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [ncm_pkg::DistW-1:0]     cfg_data_i
);

  localparam int unsigned Levels    = $clog2(PALETTE_SIZE);
  localparam int unsigned NumLeaves = 1 << Levels;
  localparam int unsigned CmpW      = (Levels > ncm_pkg::ColIdxW) ? Levels
                                                                  : ncm_pkg::ColIdxW;

  logic                      adv;
  logic                      in_acc;
  logic                      wr_acc;
  logic [CmpW-1:0]           wr_idx;
  logic [ncm_pkg::DistW-1:0] thresh_q;
  logic                      lane_vld_q;
  ncm_pkg::node_t            leaf [NumLeaves];
  ncm_pkg::node_t            root;
  logic                      root_vld;

  // whole pipeline moves unless a finished result is held back
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;
  assign wr_acc     = in_acc && (in_data_i.action == ncm_pkg::ACT_WRITE);
  assign wr_idx     = CmpW'(in_data_i.entry_index);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ncm_pkg::ThresholdReset;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // valid of the distance stage: only match words make a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
    end else if (adv) begin
      lane_vld_q <= in_valid_i && (in_data_i.action == ncm_pkg::ACT_MATCH);
    end
  end

  // one lane per palette entry; the distance is taken from the palette as it
  // stands before a write in the same cycle lands, so order is kept
  for (genvar g = 0; g < NumLeaves; g++) begin : g_lane
    if (g < PALETTE_SIZE) begin : g_used
      ncm_lane #(
        .LaneIdx (g)
      ) u_lane (
        .clk_i    (clk_i),
        .adv_i    (adv),
        .wr_en_i  (wr_acc && (wr_idx == CmpW'(g))),
        .item_i   (in_data_i),
        .thresh_i (thresh_q),
        .node_o   (leaf[g])
      );
    end else begin : g_pad
      // padding up to a power of two never qualifies
      assign leaf[g] = '{ok: 1'b0, l1_dist: ncm_pkg::NoMatchDistance,
                         idx: ncm_pkg::NodeIdxW'(g)};
    end
  end

  ncm_tree #(
    .Levels (Levels)
  ) u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (lane_vld_q),
    .leaf_i (leaf),
    .root_o (root),
    .vld_o  (root_vld)
  );

  // root stage is the output register
  assign out_valid_o               = root_vld;
  assign out_data_o.found          = root.ok;
  assign out_data_o.color_index    = root.ok ? root.idx[ncm_pkg::ColIdxW-1:0] : '0;
  assign out_data_o.best_distance  = root.ok ? root.l1_dist : ncm_pkg::NoMatchDistance;

endmodule

`default_nettype wire

>>> tb/sv/nearest_palette_color_match_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core_test
// self-checking bench for the nearest palette colour match core: a directed
// table loads the palette and probes ties, exact hits and threshold extremes,
// then random phases mix palette loads with pixels under changing thresholds.
// every result word is compared field by field with a typed value or an in-order shadow model
// ----------------------------------------------------------------------------

module nearest_palette_color_match_core_test;

  localparam int unsigned PaletteSize  = 16;
  // one distance stage plus four tree levels for sixteen entries
  localparam int unsigned PipeDepth    = 5;
  localparam int unsigned RandomPhases = 7;
  localparam int unsigned PhaseWords   = 75;
  localparam int unsigned PlanRows     = 30;

  // one line of the directed table: either a threshold write or a word,
  // with the result typed in where it is obvious
  typedef struct packed {
    logic                      is_cfg;
    logic [ncm_pkg::DistW-1:0] cfg_value;
    ncm_pkg::in_item_t         word;
    logic                      typed;
    ncm_pkg::out_item_t        want;
  } plan_row_t;

  localparam ncm_pkg::out_item_t NoHit = '{4'd0, 1'b0, ncm_pkg::NoMatchDistance};

  localparam plan_row_t DirectedPlan [PlanRows] = '{
    // whole palette first, entries 0 and 1 both black so that they tie
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd0,  8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd1,  8'd0,   8'd0,   8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd2,  8'd255, 8'd0,   8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd3,  8'd0,   8'd255, 8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd4,  8'd0,   8'd0,   8'd255}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd5,  8'd255, 8'd255, 8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd6,  8'd0,   8'd255, 8'd255}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd7,  8'd255, 8'd0,   8'd255}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd8,  8'd128, 8'd128, 8'd128}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd9,  8'd64,  8'd0,   8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd10, 8'd0,   8'd64,  8'd0},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd11, 8'd0,   8'd0,   8'd64},  1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd12, 8'd192, 8'd192, 8'd192}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd13, 8'd100, 8'd150, 8'd200}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd14, 8'd1,   8'd2,   8'd3},   1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_WRITE, 4'd15, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
    // reset threshold: tie goes to the lower entry, index field ignored
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'hF,  8'd0,   8'd0,   8'd0},   1'b1,
      '{4'd0, 1'b1, 10'd0}},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd0,  8'd255, 8'd255, 8'd255}, 1'b1,
      '{4'd15, 1'b1, 10'd0}},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'hA,  8'd130, 8'd126, 8'd129}, 1'b0, '0},
    // threshold zero: nothing can qualify, not even an exact hit
    '{1'b1, 10'd0,   '0, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd5,  8'd0,   8'd0,   8'd0},   1'b1, NoHit},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd0,  8'd128, 8'd128, 8'd128}, 1'b1, NoHit},
    // top of the range: every entry qualifies
    '{1'b1, 10'd766, '0, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd3,  8'd255, 8'd0,   8'd128}, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd0,  8'd0,   8'd255, 8'd0},   1'b1,
      '{4'd3, 1'b1, 10'd0}},
    '{1'b1, 10'd765, '0, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd7,  8'd255, 8'd255, 8'd255}, 1'b1,
      '{4'd15, 1'b1, 10'd0}},
    // threshold one: only an exact hit passes
    '{1'b1, 10'd1,   '0, 1'b0, '0},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd9,  8'd0,   8'd0,   8'd0},   1'b1,
      '{4'd0, 1'b1, 10'd0}},
    '{1'b0, 10'd0, '{ncm_pkg::ACT_MATCH, 4'd2,  8'd0,   8'd0,   8'd1},   1'b0, '0}
  };

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  ncm_pkg::in_item_t         in_data_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  ncm_pkg::out_item_t        out_data_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [ncm_pkg::DistW-1:0] cfg_data_i;

  // shadow copy of the palette and the threshold, updated at acceptance
  logic [3*ncm_pkg::ChanW-1:0] palette_shadow [PaletteSize];
  logic [ncm_pkg::DistW-1:0]   threshold_shadow;
  ncm_pkg::out_item_t          pending_matches [$];
  ncm_pkg::out_item_t          oldest;

  int unsigned fail_count       = 0;
  int unsigned words_sent       = 0;
  int unsigned palette_loads    = 0;
  int unsigned results_checked  = 0;
  int unsigned threshold_writes = 0;
  int unsigned sink_run         = 0;
  int unsigned sink_pick;

  nearest_palette_color_match_core #(
    .PALETTE_SIZE(PaletteSize)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow model
  // ---------------------------------------------------------------------------

  function automatic int unsigned chan_gap(input logic [ncm_pkg::ChanW-1:0] a,
                                           input logic [ncm_pkg::ChanW-1:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // lowest L1 distance strictly under the threshold, lowest entry on a tie
  function automatic ncm_pkg::out_item_t nearest_entry(input ncm_pkg::in_item_t px);
    ncm_pkg::out_item_t res;
    int unsigned        l1_dist;
    int unsigned        e;
    res.color_index   = '0;
    res.found         = 1'b0;
    res.best_distance = ncm_pkg::NoMatchDistance;
    for (e = 0; e < PaletteSize; e++) begin
      l1_dist = chan_gap(px.red,   palette_shadow[e][3*ncm_pkg::ChanW-1:2*ncm_pkg::ChanW]) +
                chan_gap(px.green, palette_shadow[e][2*ncm_pkg::ChanW-1:ncm_pkg::ChanW]) +
                chan_gap(px.blue,  palette_shadow[e][ncm_pkg::ChanW-1:0]);
      if (l1_dist < threshold_shadow && (!res.found || l1_dist < res.best_distance)) begin
        res.color_index   = ncm_pkg::ColIdxW'(e);
        res.found         = 1'b1;
        res.best_distance = ncm_pkg::DistW'(l1_dist);
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  // a channel close to a palette colour, so that many pixels land under the
  // threshold and the tree has real work to do
  function automatic logic [ncm_pkg::ChanW-1:0] near_channel(
      input logic [ncm_pkg::ChanW-1:0] base);
    int v;
    v = int'(base) + int'($urandom_range(0, 80)) - 40;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ncm_pkg::ChanW'(v);
  endfunction

  // roughly one palette load in five, half the pixels near an entry
  function automatic ncm_pkg::in_item_t random_word();
    ncm_pkg::in_item_t w;
    int unsigned       e;
    w.entry_index = ncm_pkg::ColIdxW'($urandom_range(0, PaletteSize - 1));
    w.red         = ncm_pkg::ChanW'($urandom_range(0, 255));
    w.green       = ncm_pkg::ChanW'($urandom_range(0, 255));
    w.blue        = ncm_pkg::ChanW'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      w.action = ncm_pkg::ACT_WRITE;
    end else begin
      w.action = ncm_pkg::ACT_MATCH;
      if ($urandom_range(0, 1) == 1) begin
        e       = $urandom_range(0, PaletteSize - 1);
        w.red   = near_channel(palette_shadow[e][3*ncm_pkg::ChanW-1:2*ncm_pkg::ChanW]);
        w.green = near_channel(palette_shadow[e][2*ncm_pkg::ChanW-1:ncm_pkg::ChanW]);
        w.blue  = near_channel(palette_shadow[e][ncm_pkg::ChanW-1:0]);
      end
    end
    return w;
  endfunction

  // mostly mid-range thresholds, now and then the edges of the range
  function automatic logic [ncm_pkg::DistW-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0, 1: begin
        return ncm_pkg::DistW'($urandom_range(0, 766));
      end
      8: begin
        case ($urandom_range(0, 3))
          0:       return ncm_pkg::DistW'(0);
          1:       return ncm_pkg::DistW'(1);
          2:       return ncm_pkg::DistW'(765);
          default: return ncm_pkg::DistW'(766);
        endcase
      end
      9: begin
        return ncm_pkg::NoMatchDistance;
      end
      default: begin
        return ncm_pkg::DistW'($urandom_range(100, 400));
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one word, hold it until taken, then update the shadow model
  task automatic send_word(input ncm_pkg::in_item_t word, input bit typed,
                           input ncm_pkg::out_item_t want, input bit burst);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    words_sent++;
    if (word.action == ncm_pkg::ACT_WRITE) begin
      palette_shadow[word.entry_index] = {word.red, word.green, word.blue};
      palette_loads++;
    end else begin
      pending_matches.push_back(typed ? want : nearest_entry(word));
    end
    gap = pick_gap(burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending, let every result out, then give trailing loads time to
  // leave the pipe since they never show on the output
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 3) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ncm_pkg::DistW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    threshold_shadow = value;
    threshold_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  // runs of stall and no stall, mostly short, now and then a long quiet or
  // long blocked stretch
  always @(posedge clk_i) begin
    if (sink_run != 0) begin
      sink_run <= sink_run - 1;
    end else begin
      sink_pick = $urandom_range(0, 99);
      if (sink_pick < 50) begin
        out_stall_i <= 1'b0;
        sink_run    <= $urandom_range(0, 7);
      end else if (sink_pick < 85) begin
        out_stall_i <= 1'b1;
        sink_run    <= $urandom_range(0, 1);
      end else if (sink_pick < 95) begin
        out_stall_i <= 1'b0;
        sink_run    <= $urandom_range(20, 60);
      end else begin
        out_stall_i <= 1'b1;
        sink_run    <= $urandom_range(10, 40);
      end
    end
  end

  // every result word taken is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_matches.size() == 0) begin
        $error("result word with nothing expected: index %0d found %0d distance %0d",
               out_data_o.color_index, out_data_o.found, out_data_o.best_distance);
        fail_count++;
      end else begin
        oldest = pending_matches.pop_front();
        results_checked++;
        if (out_data_o.color_index !== oldest.color_index) begin
          $error("color_index: expected %0d, got %0d",
                 oldest.color_index, out_data_o.color_index);
          fail_count++;
        end
        if (out_data_o.found !== oldest.found) begin
          $error("found: expected %0d, got %0d", oldest.found, out_data_o.found);
          fail_count++;
        end
        if (out_data_o.best_distance !== oldest.best_distance) begin
          $error("best_distance: expected %0d, got %0d",
                 oldest.best_distance, out_data_o.best_distance);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned row;
    int unsigned phase;
    bit          burst;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    cfg_valid_i      = 1'b0;
    cfg_data_i       = '0;
    threshold_shadow = ncm_pkg::ThresholdReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, palette loaded before the first pixel
    for (row = 0; row < PlanRows; row++) begin
      if (DirectedPlan[row].is_cfg) begin
        settle();
        write_threshold(DirectedPlan[row].cfg_value);
      end else begin
        send_word(DirectedPlan[row].word, DirectedPlan[row].typed,
                  DirectedPlan[row].want, 1'b0);
      end
    end

    // random phases, each under a fresh threshold; every third one at full
    // rate so that back-to-back words meet the output stalls
    for (phase = 0; phase < RandomPhases; phase++) begin
      settle();
      write_threshold(pick_threshold());
      burst = (phase % 3) == 1;
      repeat (PhaseWords) send_word(random_word(), 1'b0, '0, burst);
    end

    settle();
    repeat (4 * PipeDepth) @(posedge clk_i);

    $display("covered %0d words: %0d palette loads and %0d pixels, %0d threshold settings",
             words_sent, palette_loads, words_sent - palette_loads, threshold_writes);
    $display("checked %0d result words, %0d field mismatches", results_checked, fail_count);
    if (fail_count == 0 && pending_matches.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
